>>> sv/assert_macros.svh
// Assertion macros for the RTL, used by apd_recon. Each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> sv/apd_pkg.sv
package apd_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WCFG_W    = 12;
    localparam int HCFG_W    = 16;
    localparam int CFG_DW    = 16;
    localparam int CFG_IW    = 2;
    localparam int CMP_W     = (COL_W + 1 > WCFG_W) ? COL_W + 1 : WCFG_W;
    localparam int PIX_W     = 32;

    localparam logic [CFG_IW-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_IDX_ALPHA  = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Position of one pixel in the image, worked out when it is accepted.
    typedef struct packed {
        logic             first_row;
        logic             first_col;
        logic [COL_W-1:0] col;
        logic             last;
        logic             alpha_on;
    } t_pos;

    function automatic logic [7:0] recon_lane(
        input logic       first_row,
        input logic       first_col,
        input logic [7:0] left,
        input logic [7:0] above,
        input logic [7:0] res
    );
        logic [8:0] sum;
        logic [7:0] pred;
        sum = {1'b0, left} + {1'b0, above};
        if (first_row && first_col) begin
            return res;
        end
        if (first_row) begin
            pred = left;
        end else if (first_col) begin
            pred = above;
        end else begin
            pred = sum[8:1];
        end
        return pred - res;
    endfunction

endpackage

>>> sv/apd_ram.sv
module apd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/apd_ctrl.sv
module apd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [apd_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [apd_pkg::CFG_DW-1:0]    i_cfg_wdata,
    input  logic                          i_accept,
    output apd_pkg::t_pos                 o_pos
);
    import apd_pkg::*;

    logic [WCFG_W-1:0] r_width;
    logic [HCFG_W-1:0] r_height;
    logic              r_alpha;
    logic [COL_W-1:0]  r_col;
    logic [HCFG_W-1:0] r_row;

    logic [CMP_W-1:0]  w_eff;
    logic [HCFG_W-1:0] h_eff;
    logic [CMP_W-1:0]  col_next;
    logic [HCFG_W:0]   row_next;
    logic              last_col;
    logic              last_row;

    // Width zero counts as one, and anything above the line store is saturated.
    always_comb begin
        if (r_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(r_width);
        end
        h_eff    = (r_height == '0) ? HCFG_W'(1) : r_height;
        col_next = CMP_W'(r_col) + CMP_W'(1);
        row_next = {1'b0, r_row} + (HCFG_W + 1)'(1);
        last_col = col_next >= w_eff;
        last_row = row_next >= {1'b0, h_eff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WCFG_W'(1);
            r_height <= HCFG_W'(1);
            r_alpha  <= 1'b1;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_IDX_WIDTH:  r_width  <= i_cfg_wdata[WCFG_W-1:0];
                    CFG_IDX_HEIGHT: r_height <= i_cfg_wdata[HCFG_W-1:0];
                    CFG_IDX_ALPHA:  r_alpha  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : row_next[HCFG_W-1:0];
                end else begin
                    r_col <= col_next[COL_W-1:0];
                end
            end
        end
    end

    assign o_pos.first_row = (r_row == '0);
    assign o_pos.first_col = (r_col == '0);
    assign o_pos.col       = r_col;
    assign o_pos.last      = last_col && last_row;
    assign o_pos.alpha_on  = r_alpha;

endmodule

>>> sv/apd_recon.sv
`include "assert_macros.svh"

module apd_recon (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [apd_pkg::PIX_W-1:0]    i_in_data,
    input  apd_pkg::t_pos                i_pos,
    output logic                         o_accept,
    input  logic [apd_pkg::PIX_W-1:0]    i_above,
    output logic                         o_wr_en,
    output logic [apd_pkg::COL_W-1:0]    o_wr_addr,
    output logic [apd_pkg::PIX_W-1:0]    o_wr_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [apd_pkg::PIX_W-1:0]    o_out_data,
    output logic                         o_out_last
);
    import apd_pkg::*;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_res;
    t_pos             r_s1_pos;
    logic             r_fwd;
    logic [PIX_W-1:0] r_left;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_data;
    logic             r_out_last;

    logic             s1_adv;
    logic             accept;
    logic             n_fwd;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] pixel;

    assign s1_adv = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept = i_in_valid && o_in_ready;

    // With a one-pixel row the line store is read at the same edge as the previous
    // pixel is written, so the read data is stale; the left pixel is the right value.
    always_comb begin
        if (accept) begin
            n_fwd = s1_adv && (r_s1_pos.col == i_pos.col);
        end else if (s1_adv) begin
            n_fwd = 1'b0;
        end else begin
            n_fwd = r_fwd;
        end
    end

    assign above = r_fwd ? r_left : i_above;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            pixel[8*c +: 8] = recon_lane(r_s1_pos.first_row, r_s1_pos.first_col,
                                         r_left[8*c +: 8], above[8*c +: 8],
                                         r_s1_res[8*c +: 8]);
        end
        if (!r_s1_pos.alpha_on) begin
            pixel[PIX_W-1 -: 8] = ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_fwd <= n_fwd;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_left      <= pixel;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= i_in_data;
            r_s1_pos <= i_pos;
        end
        if (s1_adv) begin
            r_out_data <= pixel;
            r_out_last <= r_s1_pos.last;
        end
    end

    assign o_accept    = accept;
    assign o_wr_en     = s1_adv;
    assign o_wr_addr   = r_s1_pos.col;
    assign o_wr_data   = pixel;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    `ASSERT_IMP(a_fwd_has_item, r_fwd, r_s1_valid)
    `ASSERT_IMP(a_stall_holds_item, !o_in_ready, r_s1_valid && r_out_valid)
    `ASSERT_NXT(a_adv_gives_result, s1_adv, r_out_valid && r_left == r_out_data)
    `ASSERT_NXT(a_first_pass, s1_adv && r_s1_pos.first_row && r_s1_pos.first_col, r_out_data[7:0] == $past(r_s1_res[7:0]))

endmodule

>>> sv/average_predictor_pixel_decoder.sv
// Channel   Dir  Payload
// s_axis    in   tdata: red_residual, green_residual, blue_residual, alpha_residual
// m_axis    out  tdata: red, green, blue, alpha; tlast: last_pixel
// cfg       in   index 0 image_width, 1 image_height, 2 alpha_present
//
// One pixel per clock sustained while m_axis_tready is high; a pixel moves from
// the input register to the output register. The registered line store read runs
// alongside the input register, and the prediction sits between the two. The
// line store (one 32-bit entry per column) is the only memory and has no clearing
// pass; the block accepts pixels straight after reset.
// A stalled output holds one result and one pixel in flight before tready drops.
module average_predictor_pixel_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [apd_pkg::PIX_W-1:0]     s_axis_tdata,   // red, green, blue, alpha residuals
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [apd_pkg::PIX_W-1:0]     m_axis_tdata,   // red, green, blue, alpha
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_wr_en,
    input  logic [apd_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [apd_pkg::CFG_DW-1:0]    i_cfg_wdata
);
    import apd_pkg::*;

    t_pos             pos;
    logic             accept;
    logic [PIX_W-1:0] above;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [PIX_W-1:0] wr_data;

    apd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .o_pos       (pos)
    );

    apd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (pos.col),
        .o_rd_data (above)
    );

    apd_recon u_recon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_pos       (pos),
        .o_accept    (accept),
        .i_above     (above),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

>>> dv/tb_average_predictor_pixel_decoder.sv
module tb_average_predictor_pixel_decoder;
    import apd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned RANDOM_PIXELS = 1520;

    typedef struct packed {
        logic [PIX_W-1:0] rgba;
        logic             last;
    } t_decoded_pixel;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [PIX_W-1:0]  s_axis_tdata = '0;   // red, green, blue, alpha residuals
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [PIX_W-1:0]  m_axis_tdata;        // red, green, blue, alpha
    logic              m_axis_tlast;
    logic              i_cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = CFG_IDX_WIDTH;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;

    average_predictor_pixel_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state as the block should hold it.
    logic [WCFG_W-1:0] cfg_width = WCFG_W'(1);
    logic [HCFG_W-1:0] cfg_height = HCFG_W'(1);
    logic              cfg_alpha = 1'b1;
    logic [PIX_W-1:0]  row_above [MAX_WIDTH];
    logic [PIX_W-1:0]  left_px = '0;
    logic [COL_W-1:0]  col_cnt = '0;
    logic [15:0]       row_cnt = '0;

    logic [PIX_W-1:0]  residual_queue [$];
    t_decoded_pixel    pixels_due [$];
    bit                no_idle = 1'b0;
    int unsigned       send_gap = 0;
    int unsigned       ready_hold = 0;
    int unsigned       mismatches = 0;
    int unsigned       cycle_count = 0;

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        return cfg_height;
    endfunction

    function automatic t_decoded_pixel rebuild_pixel(input logic [PIX_W-1:0] res);
        t_decoded_pixel   result;
        logic [PIX_W-1:0] above;
        logic [7:0]       left_lane;
        logic [7:0]       up_lane;
        logic [7:0]       guess;
        logic [8:0]       lane_sum;
        int unsigned      col;
        int               c;
        bit               end_of_row;
        bit               end_of_image;
        col = col_cnt;
        above = (row_cnt != 0) ? row_above[col] : '0;
        for (c = 0; c < 4; c++) begin
            left_lane = left_px[8*c +: 8];
            up_lane = above[8*c +: 8];
            lane_sum = {1'b0, left_lane} + {1'b0, up_lane};
            if (row_cnt == 0) begin
                guess = left_lane;
            end else if (col == 0) begin
                guess = up_lane;
            end else begin
                guess = lane_sum[8:1];
            end
            if (row_cnt == 0 && col == 0) begin
                result.rgba[8*c +: 8] = res[8*c +: 8];
            end else begin
                result.rgba[8*c +: 8] = guess - res[8*c +: 8];
            end
        end
        // With alpha absent the opaque value is also what later pixels predict from.
        if (!cfg_alpha) begin
            result.rgba[31:24] = ALPHA_OPAQUE;
        end
        row_above[col] = result.rgba;
        left_px = result.rgba;
        end_of_row = (col + 1 >= eff_width());
        end_of_image = (row_cnt + 1 >= eff_height());
        result.last = end_of_row && end_of_image;
        if (end_of_row) begin
            col_cnt = '0;
            row_cnt = end_of_image ? 16'd0 : row_cnt + 16'd1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        return result;
    endfunction

    // Pixels still to come before the current image ends, under the present settings.
    function automatic int unsigned pixels_left_in_image();
        int unsigned w;
        int unsigned h;
        int unsigned row_rest;
        w = eff_width();
        h = eff_height();
        row_rest = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
        if (row_cnt + 1 >= h) return row_rest;
        return row_rest + (h - row_cnt - 1) * w;
    endfunction

    function automatic logic [PIX_W-1:0] random_residual();
        logic [PIX_W-1:0] res;
        int               c;
        res = $urandom;
        for (c = 0; c < 4; c++) begin
            case ($urandom_range(0, 5))
                0: res[8*c +: 8] = 8'h00;
                1: res[8*c +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return res;
    endfunction

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // Sender: one transaction per queued residual, with a drawn gap after each.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pixels_due.push_back(rebuild_pixel(s_axis_tdata));
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (residual_queue.size() != 0) begin
                    s_axis_tdata <= residual_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap = draw_wait();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction and stalls a drawn number of cycles after it.
    always @(posedge i_clk) begin
        t_decoded_pixel want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixels_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected pixel: rgba %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                    end
                    mismatches++;
                end else begin
                    want = pixels_due.pop_front();
                    if (m_axis_tdata[7:0] !== want.rgba[7:0]
                            || m_axis_tdata[15:8] !== want.rgba[15:8]
                            || m_axis_tdata[23:16] !== want.rgba[23:16]
                            || m_axis_tdata[31:24] !== want.rgba[31:24]
                            || m_axis_tlast !== want.last) begin
                        if (mismatches < 10) begin
                            $display({"pixel mismatch: expected rgba %h last %b, ",
                                      "got rgba %h last %b"},
                                     want.rgba, want.last, m_axis_tdata, m_axis_tlast);
                        end
                        mismatches++;
                    end
                end
                ready_hold = draw_wait();
            end else if (ready_hold != 0) begin
                ready_hold--;
            end
            m_axis_tready <= (ready_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The falling edge is used so that everything the sender did at the rising edge is seen.
    task automatic wait_drained();
        @(negedge i_clk);
        while (residual_queue.size() != 0 || s_axis_tvalid || pixels_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned width, input int unsigned height,
                             input bit alpha);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_IDX_WIDTH;
        i_cfg_wdata <= width[15:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_HEIGHT;
        i_cfg_wdata <= height[15:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_ALPHA;
        i_cfg_wdata <= {15'd0, alpha};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_width = width[WCFG_W-1:0];
        cfg_height = height[HCFG_W-1:0];
        cfg_alpha = alpha;
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count) residual_queue.push_back(random_residual());
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned head;
        random_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one-pixel images that pass straight through.
        residual_queue.push_back('0);
        residual_queue.push_back('1);
        wait_drained();
        // Zero width and height behave as one; alpha forced opaque.
        configure(0, 0, 1'b0);
        send_pixels(1);
        wait_drained();
        configure(3, 3, 1'b1);
        send_pixels(9);
        wait_drained();
        // Narrow the row, raise the height and re-enable alpha part way through an image,
        // so the next pixels predict from opaque alpha neighbours.
        configure(4, 2, 1'b0);
        send_pixels(5);
        wait_drained();
        configure(2, 3, 1'b1);
        send_pixels(pixels_left_in_image());
        wait_drained();

        // Oversized width is saturated to the line store; the row is then cut short.
        configure(4095, 2, 1'b1);
        send_pixels(5);
        wait_drained();
        configure(3, 2, 1'b0);
        send_pixels(pixels_left_in_image());
        wait_drained();

        while (random_sent < RANDOM_PIXELS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: w = 0;
                1, 2: w = $urandom_range(17, 100);
                default: w = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 9))
                0: h = 0;
                1: h = 65535;
                default: h = $urandom_range(1, 8);
            endcase
            configure(w, h, $urandom_range(0, 1));
            total = pixels_left_in_image();
            if (total > 300 || (total > 1 && $urandom_range(0, 5) == 0)) begin
                head = (total > 300) ? $urandom_range(1, 3 * eff_width())
                                     : $urandom_range(1, total - 1);
                send_pixels(head);
                wait_drained();
                // Never widen the row here, so every line store read hits a written entry.
                configure($urandom_range(0, eff_width()), $urandom_range(0, 6),
                          $urandom_range(0, 1));
                total = head + pixels_left_in_image();
                send_pixels(pixels_left_in_image());
            end else begin
                send_pixels(total);
            end
            random_sent += total;
            wait_drained();
        end

        no_idle = 1'b0;
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/apd_pkg.sv
sv/apd_ram.sv
sv/apd_ctrl.sv
sv/apd_recon.sv
sv/average_predictor_pixel_decoder.sv
dv/tb_average_predictor_pixel_decoder.sv
